// ===== rtl/pdps_pkg.sv =====
// ----------------------------------------------------------------------------
// pdps_pkg
// Shared types and constants of the proximity dedup point store.
// ----------------------------------------------------------------------------
package pdps_pkg;

  // store geometry, fixed together with the field widths below
  localparam int REGION_COUNT      = 16;
  localparam int POINTS_PER_REGION = 64;

  // fixed field widths
  localparam int FUNC_W        = 1;
  localparam int REPORTED_W    = 5;
  localparam int READ_REGION_W = 4;
  localparam int ENTRY_W       = 6;
  localparam int STATUS_W      = 3;
  localparam int COUNT_W       = 7;
  localparam int SLOT_OUT_W    = 6;
  localparam int RADIUS_W      = 48;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 48'd10486;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ADDED      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_READ_OK    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 3'd4;

  // status of the distance pipeline towards the controller
  typedef struct packed {
    logic busy;
    logic hit;
  } dist_status_t;

endpackage

// ===== rtl/pdps_ram.sv =====
// ----------------------------------------------------------------------------
// pdps_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pdps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/pdps_dist.sv =====
// ----------------------------------------------------------------------------
// pdps_dist
// Pipelined proximity test of one stored point against the new point:
// absolute differences, squares, then the compare against the radius.
// ----------------------------------------------------------------------------
module pdps_dist #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 flush,
  input  logic signed [COORD_WIDTH-1:0]        ref_x,
  input  logic signed [COORD_WIDTH-1:0]        ref_y,
  input  logic signed [COORD_WIDTH-1:0]        new_x,
  input  logic signed [COORD_WIDTH-1:0]        new_y,
  input  logic [pdps_pkg::RADIUS_W-1:0]        radius_sq,
  output pdps_pkg::dist_status_t               dstat
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int SQW   = 2 * DW;
  localparam int CMP_W = (SQW + 1 > pdps_pkg::RADIUS_W) ? SQW + 1 : pdps_pkg::RADIUS_W;

  logic signed [DW-1:0] diff_x;
  logic signed [DW-1:0] diff_y;
  logic [DW-1:0]        abs_x;
  logic [DW-1:0]        abs_y;

  logic                 d_v;
  logic [DW-1:0]        d_x;
  logic [DW-1:0]        d_y;
  logic                 q_v;
  logic [SQW-1:0]       q_x;
  logic [SQW-1:0]       q_y;

  logic [CMP_W-1:0]     sx_ext;
  logic [CMP_W-1:0]     sy_ext;
  logic [CMP_W-1:0]     r_ext;
  logic                 close;

  // signed differences and their magnitudes
  always_comb begin
    diff_x = $signed({ref_x[COORD_WIDTH-1], ref_x}) - $signed({new_x[COORD_WIDTH-1], new_x});
    diff_y = $signed({ref_y[COORD_WIDTH-1], ref_y}) - $signed({new_y[COORD_WIDTH-1], new_y});
    abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
  end

  // difference stage, then square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
      q_v <= 1'b0;
    end else begin
      d_v <= in_valid && !flush;
      q_v <= d_v && !flush;
    end
    d_x <= abs_x;
    d_y <= abs_y;
    q_x <= d_x * d_x;
    q_y <= d_y * d_y;
  end

  // compare: a single square at or above the radius never matches
  always_comb begin
    sx_ext = CMP_W'(q_x);
    sy_ext = CMP_W'(q_y);
    r_ext  = CMP_W'(radius_sq);
    close  = (sx_ext < r_ext) && (sy_ext < r_ext) && ((sx_ext + sy_ext) < r_ext);
  end

  assign dstat.hit  = q_v && close;
  assign dstat.busy = d_v || q_v;

endmodule

// ===== rtl/proximity_dedup_point_store_top.sv =====
// ----------------------------------------------------------------------------
// proximity_dedup_point_store_top
// Per-region point store with proximity deduplication on insert and a
// read-back operation for single stored points.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   in        | in_valid / in_ready  | func, reported_region, point_x/y,
//             |                      | read_region, entry_index
//   out       | out_valid/out_ready  | status, region_count, slot, stored_x/y
//   cfg       | cfg_wr_en            | cfg_wr_data (match_radius_sq)
//
// An insert reads one point of its region from the point RAM per cycle; each
// goes through the distance pipeline (difference, square and compare) and a
// match stops the scan early. One beat is in work at a time and the input is
// ready again as soon as the result is registered; a result stalled in the
// output register holds back the next one. Reset clears the region fill
// counters at once.
// ----------------------------------------------------------------------------
module proximity_dedup_point_store_top #(
  parameter int COORD_WIDTH       = 24
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration
  input  logic                                     cfg_wr_en,
  input  logic [pdps_pkg::RADIUS_W-1:0]            cfg_wr_data,
  // input channel
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [pdps_pkg::FUNC_W-1:0]              func,
  input  logic [pdps_pkg::REPORTED_W-1:0]          reported_region,
  input  logic signed [COORD_WIDTH-1:0]            point_x,
  input  logic signed [COORD_WIDTH-1:0]            point_y,
  input  logic [pdps_pkg::READ_REGION_W-1:0]       read_region,
  input  logic [pdps_pkg::ENTRY_W-1:0]             entry_index,
  // output channel
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [pdps_pkg::STATUS_W-1:0]            status,
  output logic [pdps_pkg::COUNT_W-1:0]             region_count,
  output logic [pdps_pkg::SLOT_OUT_W-1:0]          slot,
  output logic signed [COORD_WIDTH-1:0]            stored_x,
  output logic signed [COORD_WIDTH-1:0]            stored_y
);

  localparam int REGION_COUNT      = pdps_pkg::REGION_COUNT;
  localparam int POINTS_PER_REGION = pdps_pkg::POINTS_PER_REGION;
  localparam int RW    = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
  localparam int SW    = (POINTS_PER_REGION > 1) ? $clog2(POINTS_PER_REGION) : 1;
  localparam int FW    = $clog2(POINTS_PER_REGION + 1);
  localparam int AW    = RW + SW;
  localparam int DEPTH = 1 << AW;
  localparam int MW    = 2 * COORD_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_FINISH} state_t;

  state_t                              state;
  logic [pdps_pkg::RADIUS_W-1:0]       radius_sq;
  logic [FW-1:0]                       region_fill [REGION_COUNT];

  // beat in work
  logic [RW-1:0]                       region_q;
  logic [FW-1:0]                       fill_q;
  logic [FW-1:0]                       iss;
  logic                                p1_v;
  logic signed [COORD_WIDTH-1:0]       px_q;
  logic signed [COORD_WIDTH-1:0]       py_q;
  logic [pdps_pkg::ENTRY_W-1:0]        entry_q;
  logic                                entry_ok_q;

  // pending result
  logic [pdps_pkg::STATUS_W-1:0]       res_status;
  logic [pdps_pkg::COUNT_W-1:0]        res_count;
  logic [pdps_pkg::SLOT_OUT_W-1:0]     res_slot;
  logic signed [COORD_WIDTH-1:0]       res_x;
  logic signed [COORD_WIDTH-1:0]       res_y;

  // memory and pipeline wiring
  logic                                accept;
  logic [RW-1:0]                       ins_region;
  logic [RW-1:0]                       rd_region;
  logic [pdps_pkg::REPORTED_W-1:0]     rep_m1;
  logic                                entry_ok;
  logic                                issue;
  logic                                scan_done;
  logic                                has_room;
  logic                                ram_we;
  logic                                ram_re;
  logic [AW-1:0]                       ram_waddr;
  logic [AW-1:0]                       ram_raddr;
  logic [MW-1:0]                       ram_wdata;
  logic [MW-1:0]                       ram_rdata;
  logic signed [COORD_WIDTH-1:0]       rd_x;
  logic signed [COORD_WIDTH-1:0]       rd_y;
  pdps_pkg::dist_status_t              dstat;

  // clamp a region number to the last region
  function automatic logic [RW-1:0] sat_region(input logic [8:0] v);
    logic [RW-1:0] r;
    if (32'(v) >= REGION_COUNT) begin
      r = RW'(REGION_COUNT - 1);
    end else begin
      r = RW'(v);
    end
    return r;
  endfunction

  // region selection and read check
  always_comb begin
    rep_m1     = (reported_region == '0) ? '0 : reported_region - 1'b1;
    ins_region = sat_region(9'(rep_m1));
    rd_region  = sat_region(9'(read_region));
    entry_ok   = (32'(entry_index) < 32'(region_fill[rd_region]))
                 && (32'(entry_index) < POINTS_PER_REGION);
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // scan control: one stored point read per cycle until the fill or a match
  always_comb begin
    issue     = (state == S_SCAN) && !dstat.hit && (iss < fill_q);
    scan_done = (state == S_SCAN) && !dstat.hit && (iss == fill_q)
                && !p1_v && !dstat.busy;
    has_room  = 32'(fill_q) < POINTS_PER_REGION;
    ram_we    = scan_done && has_room;
    ram_waddr = {region_q, fill_q[SW-1:0]};
    ram_wdata = {py_q, px_q};
    ram_re    = issue || (accept && func == pdps_pkg::FUNC_READ);
    if (state == S_IDLE) begin
      ram_raddr = {rd_region, SW'(entry_index)};
    end else begin
      ram_raddr = {region_q, iss[SW-1:0]};
    end
  end

  assign rd_x = ram_rdata[COORD_WIDTH-1:0];
  assign rd_y = ram_rdata[MW-1:COORD_WIDTH];

  pdps_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_point_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pdps_dist #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p1_v),
    .flush     (dstat.hit),
    .ref_x     (rd_x),
    .ref_y     (rd_y),
    .new_x     (px_q),
    .new_y     (py_q),
    .radius_sq (radius_sq),
    .dstat     (dstat)
  );

  // controller, fill counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      p1_v      <= 1'b0;
      radius_sq <= pdps_pkg::RADIUS_RESET;
      for (int i = 0; i < REGION_COUNT; i++) begin
        region_fill[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        radius_sq <= cfg_wr_data;
      end
      p1_v <= issue;
      if (issue) begin
        iss <= iss + 1'b1;
      end
      // result taken; finish reloads the register itself
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            px_q    <= point_x;
            py_q    <= point_y;
            entry_q <= entry_index;
            iss     <= '0;
            if (func == pdps_pkg::FUNC_READ) begin
              region_q   <= rd_region;
              fill_q     <= region_fill[rd_region];
              entry_ok_q <= entry_ok;
              state      <= S_READ;
            end else begin
              region_q <= ins_region;
              fill_q   <= region_fill[ins_region];
              state    <= S_SCAN;
            end
          end
        end
        S_READ: begin
          res_count <= pdps_pkg::COUNT_W'(fill_q);
          if (entry_ok_q) begin
            res_status <= pdps_pkg::ST_READ_OK;
            res_slot   <= pdps_pkg::SLOT_OUT_W'(entry_q);
            res_x      <= rd_x;
            res_y      <= rd_y;
          end else begin
            res_status <= pdps_pkg::ST_READ_EMPTY;
            res_slot   <= '0;
            res_x      <= '0;
            res_y      <= '0;
          end
          state <= S_FINISH;
        end
        S_SCAN: begin
          res_x <= '0;
          res_y <= '0;
          if (dstat.hit) begin
            res_status <= pdps_pkg::ST_DUPLICATE;
            res_count  <= pdps_pkg::COUNT_W'(fill_q);
            res_slot   <= '0;
            state      <= S_FINISH;
          end else if (scan_done) begin
            if (has_room) begin
              region_fill[region_q] <= fill_q + 1'b1;
              res_status <= pdps_pkg::ST_ADDED;
              res_count  <= pdps_pkg::COUNT_W'(fill_q + 1'b1);
              res_slot   <= pdps_pkg::SLOT_OUT_W'(fill_q);
            end else begin
              res_status <= pdps_pkg::ST_FULL;
              res_count  <= pdps_pkg::COUNT_W'(fill_q);
              res_slot   <= '0;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            region_count <= res_count;
            slot         <= res_slot;
            stored_x     <= res_x;
            stored_y     <= res_y;
            state        <= S_IDLE;
          end
        end
      endcase
    end
  end

  // checks on the controller
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input accepted again before the beat in work was done");

  a_write_quiet : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (!p1_v && !dstat.busy))
    else $error("point written while scan reads are still in flight");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (32'(fill_q) <= POINTS_PER_REGION))
    else $error("region fill above store capacity");

  a_finish_hold : assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_valid && !out_ready) |=> (state == S_FINISH))
    else $error("result left finish while the output register was stalled");

endmodule
